>>> hw/rtl/rtca_pkg.sv
// ----------------------------------------------------------------------------
// rtca_pkg - shared types and constants for the RTC calendar block
// Command codes, register indexes, calendar constants and the structs passed
// between the clock, alarm and top-level modules.
// ----------------------------------------------------------------------------
package rtca_pkg;

  // Command codes carried in the op field
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SET_TIME = 2'd1;
  localparam logic [1:0] OP_SET_ALL  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SEC_ALARM  = 2'd0;
  localparam logic [1:0] REG_MIN_ALARM  = 2'd1;
  localparam logic [1:0] REG_HOUR_ALARM = 2'd2;

  // Time-of-day limits
  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX = 5'd23;

  // Day limits per month class
  localparam logic [4:0] DAYS_LONG  = 5'd31;
  localparam logic [4:0] DAYS_SHORT = 5'd30;
  localparam logic [4:0] DAYS_FEB   = 5'd28;
  localparam logic [4:0] DAYS_LEAP  = 5'd29;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Divisibility by 25: y * inverse(25) mod 2^16 lands at or below 65535/25
  // exactly when y is a multiple of 25.
  localparam logic [15:0] YEAR_INV25    = 16'h5C29;
  localparam logic [15:0] YEAR_DIV25_MAX = 16'd2621;

  // One input beat
  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  new_hour;
    logic [5:0]  new_minute;
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [15:0] new_year;
  } rtca_item_t;

  // Time and date
  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } rtca_time_t;

  // Control into one alarm unit
  typedef struct packed {
    logic       tick;
    logic       cfg_we;
    logic [7:0] cfg_data;
  } rtca_alarm_ctl_t;

endpackage

>>> hw/rtl/rtca_ifs.sv
// ----------------------------------------------------------------------------
// rtca_ifs - valid/ready channels of the RTC calendar block
// Command input channel, result output channel and register write channel.
// ----------------------------------------------------------------------------

// Command channel
interface rtca_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [4:0]  new_hour;
  logic [5:0]  new_minute;
  logic [4:0]  new_day;
  logic [3:0]  new_month;
  logic [15:0] new_year;

  modport source (output valid, op, new_hour, new_minute, new_day, new_month, new_year,
                  input ready);
  modport sink   (input valid, op, new_hour, new_minute, new_day, new_month, new_year,
                  output ready);
endinterface

// Result channel
interface rtca_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  hour_now;
  logic [5:0]  minute_now;
  logic [5:0]  second_now;
  logic [4:0]  day_now;
  logic [3:0]  month_now;
  logic [15:0] year_now;
  logic        second_alarm_fired;
  logic        minute_alarm_fired;
  logic        hour_alarm_fired;

  modport source (output valid, hour_now, minute_now, second_now, day_now, month_now,
                  year_now, second_alarm_fired, minute_alarm_fired, hour_alarm_fired,
                  input ready);
  modport sink   (input valid, hour_now, minute_now, second_now, day_now, month_now,
                  year_now, second_alarm_fired, minute_alarm_fired, hour_alarm_fired,
                  output ready);
endinterface

// Register write channel
interface rtca_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [7:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

>>> hw/rtl/rtca_clock.sv
// ----------------------------------------------------------------------------
// rtca_clock - time-of-day and Gregorian date registers
// Holds h:m:s and day/month/year, works out the state after one command and
// commits it when the command moves on to the result register.
// ----------------------------------------------------------------------------
module rtca_clock
  import rtca_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  rtca_item_t item,
  output rtca_time_t now_nxt
);

  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [15:0] year_r, year_nxt;

  logic [31:0] year_prod;
  logic        div25;
  logic        leap;
  logic [4:0]  day_adv;
  logic [3:0]  month_adv;
  logic [15:0] year_adv;
  logic        day_wrap;

  // Leap year: div by 4, and if div by 100 then also by 400 (i.e. by 16)
  assign year_prod = 32'(year_r) * 32'(YEAR_INV25);
  assign div25     = (year_prod[15:0] <= YEAR_DIV25_MAX);
  assign leap      = (year_r[1:0] == 2'd0) && (!div25 || (year_r[3:0] == 4'd0));

  // Date after a day wrap; invalid months hold the date
  always_comb begin
    day_adv   = day_r;
    month_adv = month_r;
    year_adv  = year_r;
    unique case (month_r)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
        if (day_r < DAYS_LONG) begin
          day_adv = day_r + 5'd1;
        end else if (month_r != MONTH_DEC) begin
          day_adv   = 5'd1;
          month_adv = month_r + 4'd1;
        end else begin
          day_adv   = 5'd1;
          month_adv = 4'd1;
          year_adv  = year_r + 16'd1;
        end
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        if (day_r < DAYS_SHORT) begin
          day_adv = day_r + 5'd1;
        end else begin
          day_adv   = 5'd1;
          month_adv = month_r + 4'd1;
        end
      end
      MONTH_FEB: begin
        if (day_r < DAYS_FEB) begin
          day_adv = day_r + 5'd1;
        end else if ((day_r == DAYS_FEB && !leap) || day_r == DAYS_LEAP) begin
          day_adv   = 5'd1;
          month_adv = month_r + 4'd1;
        end else if (day_r == DAYS_FEB) begin
          day_adv = DAYS_LEAP;
        end
      end
      default: begin
      end
    endcase
  end

  assign day_wrap = (sec_r >= SEC_MAX) && (min_r >= MIN_MAX) && (hour_r >= HOUR_MAX);

  // Next state per command
  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    unique case (item.op)
      OP_TICK: begin
        if (sec_r < SEC_MAX) begin
          sec_nxt = sec_r + 6'd1;
        end else begin
          sec_nxt = 6'd0;
          if (min_r < MIN_MAX) begin
            min_nxt = min_r + 6'd1;
          end else begin
            min_nxt = 6'd0;
            if (hour_r < HOUR_MAX) begin
              hour_nxt = hour_r + 5'd1;
            end else begin
              hour_nxt  = 5'd0;
              day_nxt   = day_adv;
              month_nxt = month_adv;
              year_nxt  = year_adv;
            end
          end
        end
      end
      OP_SET_TIME, OP_SET_ALL: begin
        hour_nxt = (item.new_hour > HOUR_MAX) ? HOUR_MAX : item.new_hour;
        min_nxt  = (item.new_minute > MIN_MAX) ? MIN_MAX : item.new_minute;
        sec_nxt  = 6'd0;
        if (item.op == OP_SET_ALL) begin
          day_nxt   = item.new_day;
          month_nxt = item.new_month;
          year_nxt  = item.new_year;
        end
      end
      default: begin
      end
    endcase
  end

  assign now_nxt = '{hour: hour_nxt, minute: min_nxt, second: sec_nxt,
                     day: day_nxt, month: month_nxt, year: year_nxt};

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= 6'd0;
      min_r   <= 6'd0;
      hour_r  <= 5'd0;
      day_r   <= 5'd1;
      month_r <= 4'd1;
      year_r  <= 16'd0;
    end else if (adv) begin
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
    end
  end

  // Checks
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sec_r <= SEC_MAX) && (min_r <= MIN_MAX) && (hour_r <= HOUR_MAX))
    else $error("time of day out of range");

  a_sec_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item.op == OP_TICK && sec_r < SEC_MAX) |=> (sec_r == $past(sec_r) + 6'd1))
    else $error("tick did not advance the second");

  a_date_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item.op == OP_TICK && !day_wrap) |=>
      ($stable(day_r) && $stable(month_r) && $stable(year_r)))
    else $error("date moved without a day wrap");

endmodule

>>> hw/rtl/rtca_alarm.sv
// ----------------------------------------------------------------------------
// rtca_alarm - one interval alarm
// Counts changes of a watched counter and fires once every interval changes;
// holds its interval register, remaining count and last-seen value.
// ----------------------------------------------------------------------------
module rtca_alarm
  import rtca_pkg::*;
#(
  parameter int unsigned ALARM_COUNT_BITS = 8
)
(
  input  logic            clk,
  input  logic            rst_n,
  input  rtca_alarm_ctl_t ctl,
  input  logic [5:0]      value,
  output logic            fire
);

  localparam int unsigned ExtW = ALARM_COUNT_BITS + 8;

  logic [7:0]                  interval_r, interval_nxt;
  logic [ALARM_COUNT_BITS-1:0] remaining_r, remaining_nxt;
  logic [5:0]                  last_r, last_nxt;
  logic                        seen_r, seen_nxt;

  logic [ExtW-1:0]             wdata_ext;
  logic [ExtW-1:0]             interval_ext;
  logic [ALARM_COUNT_BITS-1:0] rem_dec;

  // Interval kept to the counter width when loaded
  assign wdata_ext    = {{ALARM_COUNT_BITS{1'b0}}, ctl.cfg_data};
  assign interval_ext = {{ALARM_COUNT_BITS{1'b0}}, interval_r};
  assign rem_dec      = remaining_r - ALARM_COUNT_BITS'(1);

  // Register write, or count one change on a tick
  always_comb begin
    interval_nxt  = interval_r;
    remaining_nxt = remaining_r;
    last_nxt      = last_r;
    seen_nxt      = seen_r;
    fire          = 1'b0;
    if (ctl.cfg_we) begin
      interval_nxt  = ctl.cfg_data;
      remaining_nxt = wdata_ext[ALARM_COUNT_BITS-1:0];
    end else if (ctl.tick) begin
      if (!seen_r) begin
        seen_nxt = 1'b1;
        last_nxt = value;
      end else if (last_r != value) begin
        last_nxt = value;
        if (interval_r != 8'd0) begin
          if (rem_dec == '0) begin
            remaining_nxt = interval_ext[ALARM_COUNT_BITS-1:0];
            fire          = 1'b1;
          end else begin
            remaining_nxt = rem_dec;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= 8'd0;
      remaining_r <= '0;
      last_r      <= 6'd0;
      seen_r      <= 1'b0;
    end else begin
      interval_r  <= interval_nxt;
      remaining_r <= remaining_nxt;
      last_r      <= last_nxt;
      seen_r      <= seen_nxt;
    end
  end

  // Checks
  a_fire_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (interval_r != 8'd0) && seen_r && ctl.tick)
    else $error("alarm fired while disabled or idle");

  a_fire_reload: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (remaining_r == $past(interval_ext[ALARM_COUNT_BITS-1:0])))
    else $error("alarm count not reloaded after firing");

endmodule

>>> hw/rtl/rtc_calendar_interval_alarms_top.sv
// ----------------------------------------------------------------------------
// rtc_calendar_interval_alarms_top - RTC with Gregorian calendar and alarms
// Input register, clock/date state, three interval alarms and result register.
// ----------------------------------------------------------------------------
// Each command beat (tick, set time, or set time and date) gives one result
// beat carrying the time, date and three alarm fire flags. A beat is taken
// into an input register; once the output register is free, the clock,
// calendar and alarm logic update and the result is captured in the output
// register. The block takes one beat every cycle while results are taken;
// one further beat is held in the input register while a result waits on
// the output side, after which in_ch.ready drops until the result is taken.
// Register writes are taken every cycle and reload the matching alarm count.
module rtc_calendar_interval_alarms_top
  import rtca_pkg::*;
#(
  parameter int unsigned ALARM_COUNT_BITS = 8
)
(
  input  logic       clk,
  input  logic       rst_n,
  rtca_in_if.sink    in_ch,
  rtca_out_if.source out_ch,
  rtca_cfg_if.sink   cfg_ch
);

  logic            s1_valid_r;
  rtca_item_t      s1_item_r;
  logic            s1_adv;
  logic            tick;

  logic            out_valid_r;
  rtca_time_t      out_time_r;
  logic [2:0]      out_fire_r;

  rtca_time_t      now_nxt;
  rtca_alarm_ctl_t ctl_sec, ctl_min, ctl_hour;
  logic            fire_sec, fire_min, fire_hour;

  // Handshakes
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign cfg_ch.ready = 1'b1;
  assign tick        = s1_adv && (s1_item_r.op == OP_TICK);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= '{op: in_ch.op, new_hour: in_ch.new_hour, new_minute: in_ch.new_minute,
                     new_day: in_ch.new_day, new_month: in_ch.new_month,
                     new_year: in_ch.new_year};
    end
  end

  // Clock and calendar
  rtca_clock u_clock (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (s1_adv),
    .item    (s1_item_r),
    .now_nxt (now_nxt)
  );

  // Alarms watch the counters after this tick
  assign ctl_sec  = '{tick: tick, cfg_we: cfg_ch.valid && (cfg_ch.addr == REG_SEC_ALARM),
                      cfg_data: cfg_ch.wdata};
  assign ctl_min  = '{tick: tick, cfg_we: cfg_ch.valid && (cfg_ch.addr == REG_MIN_ALARM),
                      cfg_data: cfg_ch.wdata};
  assign ctl_hour = '{tick: tick, cfg_we: cfg_ch.valid && (cfg_ch.addr == REG_HOUR_ALARM),
                      cfg_data: cfg_ch.wdata};

  rtca_alarm #(.ALARM_COUNT_BITS(ALARM_COUNT_BITS)) u_alarm_sec (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_sec),
    .value (now_nxt.second),
    .fire  (fire_sec)
  );

  rtca_alarm #(.ALARM_COUNT_BITS(ALARM_COUNT_BITS)) u_alarm_min (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_min),
    .value (now_nxt.minute),
    .fire  (fire_min)
  );

  rtca_alarm #(.ALARM_COUNT_BITS(ALARM_COUNT_BITS)) u_alarm_hour (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_hour),
    .value ({1'b0, now_nxt.hour}),
    .fire  (fire_hour)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_time_r <= now_nxt;
      out_fire_r <= {fire_hour, fire_min, fire_sec};
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.hour_now           = out_time_r.hour;
  assign out_ch.minute_now         = out_time_r.minute;
  assign out_ch.second_now         = out_time_r.second;
  assign out_ch.day_now            = out_time_r.day;
  assign out_ch.month_now          = out_time_r.month;
  assign out_ch.year_now           = out_time_r.year;
  assign out_ch.second_alarm_fired = out_fire_r[0];
  assign out_ch.minute_alarm_fired = out_fire_r[1];
  assign out_ch.hour_alarm_fired   = out_fire_r[2];

  // Checks
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled with room in the pipe");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced beat produced no result");

  a_fire_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_sec || fire_min || fire_hour) |-> tick)
    else $error("alarm fired outside a tick");

endmodule
